/* hdl/timed_motor_position_tracker_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the timed motor position tracker
// Short forms for the clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TIMED_MOTOR_POSITION_TRACKER_MACROS_SVH
`define TIMED_MOTOR_POSITION_TRACKER_MACROS_SVH

// Same-cycle implication, masked while reset is applied
`define TMPT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is applied
`define TMPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well
`define TMPT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tmpt_pkg.sv */
// ----------------------------------------------------------------------------
// tmpt_pkg
// Types, codes and helpers shared by the motor position tracker.
// ----------------------------------------------------------------------------
package tmpt_pkg;

    localparam int MOTOR_COUNT  = 4;
    localparam int MOTOR_IDX_W  = 2;
    localparam int REPORT_COUNT = (MOTOR_COUNT < 4) ? MOTOR_COUNT : 4;

    localparam logic [15:0] TICKS_PER_MM_RESET = 16'd100;

    typedef enum logic [3:0] {
        KIND_TICK       = 4'd0,
        KIND_SET_TARGET = 4'd1,
        KIND_STOP       = 4'd2,
        KIND_STOP_ALL   = 4'd3,
        KIND_FWD        = 4'd4,
        KIND_BACK       = 4'd5,
        KIND_CAL        = 4'd6,
        KIND_ALL_FWD    = 4'd7,
        KIND_ALL_BACK   = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } dir_t;

    localparam logic [2:0] MF_FWD  = 3'b001;
    localparam logic [2:0] MF_BACK = 3'b010;
    localparam logic [2:0] MF_CAL  = 3'b100;

    localparam logic [1:0] MODE_TARGET = 2'd0;
    localparam logic [1:0] MODE_FWD    = 2'd1;
    localparam logic [1:0] MODE_BACK   = 2'd2;
    localparam logic [1:0] MODE_CAL    = 2'd3;

    // Command broadcast to one motor lane
    typedef struct packed {
        logic        fire;
        logic [3:0]  kind;
        logic        sel;
        logic [31:0] target;
        logic        all_fwd;
        logic        all_back;
        logic [15:0] ticks_per_mm;
    } lane_cmd_t;

    // Visible state of one motor lane
    typedef struct packed {
        logic        run;
        dir_t        dir;
        logic [2:0]  flags;
        logic [31:0] position;
        logic [31:0] manual;
    } lane_status_t;

    function automatic logic [1:0] mode_code(input logic [2:0] flags);
        logic [1:0] code;
        if ((flags & MF_FWD) != 3'b000) begin
            code = MODE_FWD;
        end else if ((flags & MF_BACK) != 3'b000) begin
            code = MODE_BACK;
        end else if ((flags & MF_CAL) != 3'b000) begin
            code = MODE_CAL;
        end else begin
            code = MODE_TARGET;
        end
        return code;
    endfunction

endpackage

/* hdl/timed_motor_position_tracker.sv */
// ----------------------------------------------------------------------------
// timed_motor_position_tracker
// Time-based position estimate for four direction-bit driven DC motors.
// ----------------------------------------------------------------------------
// Each transaction is a millisecond tick or a motor command and returns one
// result with the drive bits, run flags and the addressed motor's mode,
// position and manual distance as they stand after the update. The block
// takes one transaction per clock while no held result stalls it; each
// transaction is registered in the input register, then all four motor
// lanes update in parallel into the result register, which presents the
// result until it is accepted. A held result stalls the input register
// only, so one further transaction is still taken.
// ticks_per_mm is written through cfg_wr_en/cfg_wr_data and resets to 100.
// ----------------------------------------------------------------------------
module timed_motor_position_tracker
    import tmpt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [15:0]            cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [3:0]             s_kind,
    input  logic [MOTOR_IDX_W-1:0] s_motor_index,
    input  logic signed [31:0]     s_target_mm,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_drive_bits,
    output logic [3:0]             m_running_mask,
    output logic [1:0]             m_mode,
    output logic signed [31:0]     m_position_mm,
    output logic signed [31:0]     m_manual_mm
);

    logic [15:0]            tpm_reg;
    logic                   in_valid_reg, in_valid_next;
    logic [3:0]             in_kind_reg;
    logic [MOTOR_IDX_W-1:0] in_idx_reg;
    logic [31:0]            in_target_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             drive_reg,  drive_next;
    logic [3:0]             run_reg,    run_next;
    logic [1:0]             mode_reg,   mode_next;
    logic [31:0]            pos_reg,    pos_next;
    logic [31:0]            man_reg,    man_next;

    logic         out_free;
    logic         fire;
    logic         s_accept;
    logic         idx_ok;
    logic         all_fwd;
    logic         all_back;
    lane_cmd_t    lane_cmd [MOTOR_COUNT];
    lane_status_t st_cur   [MOTOR_COUNT];
    lane_status_t st_nxt   [MOTOR_COUNT];

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;
    assign fire     = in_valid_reg && out_free;
    assign idx_ok   = (32'(in_idx_reg) < MOTOR_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpm_reg       <= TICKS_PER_MM_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tpm_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg   <= s_kind;
            in_idx_reg    <= s_motor_index;
            in_target_reg <= s_target_mm;
        end
        if (fire) begin
            drive_reg <= drive_next;
            run_reg   <= run_next;
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            man_reg   <= man_next;
        end
    end

    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    // toggle-all needs every motor's mode before the update
    always_comb begin
        all_fwd  = 1'b1;
        all_back = 1'b1;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            if ((st_cur[i].flags & MF_FWD) == 3'b000) begin
                all_fwd = 1'b0;
            end
            if ((st_cur[i].flags & MF_BACK) == 3'b000) begin
                all_back = 1'b0;
            end
        end
    end

    for (genvar g = 0; g < MOTOR_COUNT; g++) begin : g_lane
        assign lane_cmd[g] = '{fire: fire, kind: in_kind_reg,
                               sel: idx_ok && (32'(in_idx_reg) == g),
                               target: in_target_reg, all_fwd: all_fwd,
                               all_back: all_back, ticks_per_mm: tpm_reg};

        tmpt_motor_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (lane_cmd[g]),
            .status_cur (st_cur[g]),
            .status_nxt (st_nxt[g])
        );
    end

    always_comb begin
        drive_next = 8'd0;
        run_next   = 4'd0;
        for (int i = 0; i < REPORT_COUNT; i++) begin
            if (st_nxt[i].run) begin
                run_next[i] = 1'b1;
                if (st_nxt[i].dir == DIR_FWD) begin
                    drive_next[2*i] = 1'b1;
                end else if (st_nxt[i].dir == DIR_BACK) begin
                    drive_next[2*i+1] = 1'b1;
                end
            end
        end
        if (idx_ok) begin
            mode_next = mode_code(st_nxt[in_idx_reg].flags);
            pos_next  = st_nxt[in_idx_reg].position;
            man_next  = st_nxt[in_idx_reg].manual;
        end else begin
            mode_next = MODE_TARGET;
            pos_next  = 32'd0;
            man_next  = 32'd0;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_drive_bits   = drive_reg;
    assign m_running_mask = run_reg;
    assign m_mode         = mode_reg;
    assign m_position_mm  = pos_reg;
    assign m_manual_mm    = man_reg;

endmodule

/* hdl/tmpt_motor_lane.sv */
// ----------------------------------------------------------------------------
// tmpt_motor_lane
// State of one motor and its update for one command or millisecond tick.
// ----------------------------------------------------------------------------
module tmpt_motor_lane
    import tmpt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  lane_cmd_t    cmd,
    output lane_status_t status_cur,
    output lane_status_t status_nxt
);

    logic        run_reg,      run_next;
    dir_t        dir_reg,      dir_next;
    logic [2:0]  flags_reg,    flags_next;
    logic [31:0] pos_reg,      pos_next;
    logic [31:0] man_reg,      man_next;
    logic [31:0] goal_reg,     goal_next;
    logic [15:0] elapsed_reg,  elapsed_next;

    logic [15:0] elapsed_inc;
    logic [31:0] man_fwd;
    logic [31:0] man_back;
    logic [2:0]  tog_flag;
    dir_t        tog_dir;
    logic        all_set;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b0;
            dir_reg     <= DIR_NONE;
            flags_reg   <= 3'b000;
            pos_reg     <= 32'd0;
            man_reg     <= 32'd0;
            goal_reg    <= 32'd0;
            elapsed_reg <= 16'd0;
        end else begin
            run_reg     <= run_next;
            dir_reg     <= dir_next;
            flags_reg   <= flags_next;
            pos_reg     <= pos_next;
            man_reg     <= man_next;
            goal_reg    <= goal_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_comb begin
        run_next     = run_reg;
        dir_next     = dir_reg;
        flags_next   = flags_reg;
        pos_next     = pos_reg;
        man_next     = man_reg;
        goal_next    = goal_reg;
        elapsed_next = elapsed_reg;

        // saturate the millisecond count
        elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
        man_fwd     = man_reg + 32'd1;
        man_back    = man_reg - 32'd1;

        case (cmd.kind)
            KIND_FWD, KIND_ALL_FWD: begin
                tog_flag = MF_FWD;
                tog_dir  = DIR_FWD;
            end
            KIND_BACK, KIND_ALL_BACK: begin
                tog_flag = MF_BACK;
                tog_dir  = DIR_BACK;
            end
            default: begin
                tog_flag = MF_CAL;
                tog_dir  = DIR_BACK;
            end
        endcase
        all_set = (cmd.kind == KIND_ALL_FWD) ? cmd.all_fwd : cmd.all_back;

        if (cmd.fire) begin
            case (cmd.kind)
                KIND_TICK: begin
                    if (run_reg) begin
                        if (elapsed_inc < cmd.ticks_per_mm) begin
                            elapsed_next = elapsed_inc;
                        end else begin
                            elapsed_next = 16'd0;
                            case (dir_reg)
                                DIR_FWD:  pos_next = pos_reg + 32'd1;
                                DIR_BACK: pos_next = pos_reg - 32'd1;
                                default:  pos_next = pos_reg;
                            endcase
                            // target mode also walks the manual counter towards the goal
                            if (flags_reg == 3'b000) begin
                                case (dir_reg)
                                    DIR_FWD: begin
                                        man_next = man_fwd;
                                        if ($signed(man_fwd) >= $signed(goal_reg)) begin
                                            run_next   = 1'b0;
                                            flags_next = 3'b000;
                                        end
                                    end
                                    DIR_BACK: begin
                                        man_next = man_back;
                                        if ($signed(goal_reg) >= $signed(man_back)) begin
                                            run_next   = 1'b0;
                                            flags_next = 3'b000;
                                        end
                                    end
                                    default: man_next = man_reg;
                                endcase
                            end
                        end
                    end
                end
                KIND_SET_TARGET: begin
                    if (cmd.sel) begin
                        goal_next = cmd.target;
                        if (cmd.target == pos_reg) begin
                            run_next   = 1'b0;
                            flags_next = 3'b000;
                        end else begin
                            run_next     = 1'b1;
                            elapsed_next = 16'd0;
                            dir_next     = ($signed(cmd.target) >= $signed(pos_reg)) ?
                                           DIR_FWD : DIR_BACK;
                        end
                    end
                end
                KIND_STOP: begin
                    if (cmd.sel) begin
                        run_next   = 1'b0;
                        flags_next = 3'b000;
                    end
                end
                KIND_STOP_ALL: begin
                    run_next   = 1'b0;
                    flags_next = 3'b000;
                end
                KIND_FWD, KIND_BACK, KIND_CAL: begin
                    if (cmd.sel) begin
                        if ((flags_reg & tog_flag) != 3'b000) begin
                            run_next   = 1'b0;
                            flags_next = 3'b000;
                        end else begin
                            flags_next   = tog_flag;
                            run_next     = 1'b1;
                            dir_next     = tog_dir;
                            elapsed_next = 16'd0;
                        end
                    end
                end
                KIND_ALL_FWD, KIND_ALL_BACK: begin
                    if (all_set) begin
                        run_next   = 1'b0;
                        flags_next = 3'b000;
                    end else begin
                        flags_next   = tog_flag;
                        run_next     = 1'b1;
                        dir_next     = tog_dir;
                        elapsed_next = 16'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign status_cur = '{run: run_reg, dir: dir_reg, flags: flags_reg,
                          position: pos_reg, manual: man_reg};
    assign status_nxt = '{run: run_next, dir: dir_next, flags: flags_next,
                          position: pos_next, manual: man_next};

endmodule

/* hdl/tmpt_checker.sv */
// ----------------------------------------------------------------------------
// tmpt_checker
// Port-level checks on the result channel of the motor position tracker.
// ----------------------------------------------------------------------------
`include "timed_motor_position_tracker_macros.svh"

module tmpt_checker
    import tmpt_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [7:0]         m_drive_bits,
    input logic [3:0]         m_running_mask,
    input logic [1:0]         m_mode,
    input logic signed [31:0] m_position_mm,
    input logic signed [31:0] m_manual_mm
);

    logic drive_in_run;
    logic drive_one_way;
    logic accept_seen;

    assign accept_seen = s_valid && s_ready;

    // a motor drives only while it runs
    assign drive_in_run =
        (m_drive_bits[1:0] == 2'b00 || m_running_mask[0]) &&
        (m_drive_bits[3:2] == 2'b00 || m_running_mask[1]) &&
        (m_drive_bits[5:4] == 2'b00 || m_running_mask[2]) &&
        (m_drive_bits[7:6] == 2'b00 || m_running_mask[3]);

    // never forward and backward together
    assign drive_one_way =
        (m_drive_bits[1:0] != 2'b11) && (m_drive_bits[3:2] != 2'b11) &&
        (m_drive_bits[5:4] != 2'b11) && (m_drive_bits[7:6] != 2'b11);

    `TMPT_ASSERT_NEXT_ALWAYS(a_reset_clears_result, aclk, !aresetn, !m_valid, "result valid after reset")

    `TMPT_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_drive_bits) && $stable(m_running_mask) && $stable(m_mode) && $stable(m_position_mm) && $stable(m_manual_mm), "stalled result changed")

    `TMPT_ASSERT_IMPL(a_drive_needs_run, aclk, aresetn, m_valid, drive_in_run, "drive bit set on a stopped motor")

    `TMPT_ASSERT_IMPL(a_drive_one_way, aclk, aresetn, m_valid, drive_one_way, "both drive bits set for one motor")

    `TMPT_ASSERT_NEXT(a_result_follows, aclk, aresetn, accept_seen && !m_valid, ##1 m_valid, "no result two cycles after an idle transaction")

endmodule

bind timed_motor_position_tracker tmpt_checker u_tmpt_checker (.*);
